/* hw/rtl/ffa_pkg.sv */
// Shared constants, codes and control types of the first-fit allocator.
package ffa_pkg;

	localparam int POOL_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int SPLIT_SLACK_DEF  = 32;

	localparam int REQ_W    = 16;
	localparam int REL_W    = 13;
	localparam int OFFSET_W = 12;
	localparam int ID_W     = 16;
	// Arithmetic width for size, offset and split math.
	localparam int CALC_W   = 18;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_ZERO    = 2'd1,
		ST_NOFIT   = 2'd2,
		ST_IGNORED = 2'd3
	} status_code_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_SPLIT,
		S_LINK,
		S_MARK,
		S_FREE,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic         clr_step;
		logic         accept;
		logic         walk_step;
		logic         load_found;
		logic         wr_split;
		logic         wr_link;
		logic         wr_mark;
		logic         free_wr;
		logic         res_load;
		logic         grant;
		status_code_t res_code;
		logic         out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic req_free;
		logic need_zero;
		logic head_bad;
		logic free_bad;
		logic fit;
		logic next_bad;
		logic steps_over;
		logic split_now;
		logic mark_ok;
		logic out_busy;
	} sts_t;

endpackage

/* hw/rtl/first_fit_free_list_allocator_core.sv */
// Allocate: accept, header walk, optional split write, link and mark writes, result; if
// nothing fits, the walk ends in the result. Free: accept, free write, result; rejected
// at accept: result loaded at accept. The next item is taken in the cycle after the result
// is loaded into the output register, which holds while stalled. Reset: arst_n clears
// control state, then a clearing pass writes every header (in_stall stays high meanwhile);
// config writes are always taken. Top level of the first-fit free-list allocator.
module first_fit_free_list_allocator_core #(
	parameter int POOL_BYTES   = ffa_pkg::POOL_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
	parameter int SPLIT_SLACK  = ffa_pkg::SPLIT_SLACK_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration: split_enable
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	// request items
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [ffa_pkg::REQ_W-1:0]    request_size,
	input  logic [ffa_pkg::REL_W-1:0]    release_offset,
	// result items
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [ffa_pkg::OFFSET_W-1:0] payload_offset,
	output logic [ffa_pkg::ID_W-1:0]     block_id
);
	import ffa_pkg::*;

	// Controller sequences: clear pass, accept, header walk, up to three
	// header writes, then hand-off to the output register.
	cmd_t cmd;
	sts_t sts;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath holds the header RAM ({next link, size} per header offset),
	// list head, id counter, walk registers and the output register.
	ffa_dp #(
		.POOL_BYTES   (POOL_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.SPLIT_SLACK  (SPLIT_SLACK)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mode           (mode),
		.request_size   (request_size),
		.release_offset (release_offset),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.status         (status),
		.payload_offset (payload_offset),
		.block_id       (block_id),
		.cmd            (cmd),
		.sts            (sts)
	);
endmodule

/* hw/rtl/ffa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/ffa_ctrl.sv */
// Controller state machine of the first-fit allocator.
module ffa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ffa_pkg::sts_t sts,
	output ffa_pkg::cmd_t cmd
);
	import ffa_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (sts.req_free) begin
						state_d = sts.free_bad ? S_DONE : S_FREE;
					end else if (sts.need_zero || sts.head_bad) begin
						state_d = S_DONE;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (sts.fit) begin
					state_d = sts.split_now ? S_SPLIT : S_LINK;
				end else if (sts.next_bad || sts.steps_over) begin
					state_d = S_DONE;
				end
			end
			S_SPLIT: state_d = S_LINK;
			S_LINK:  state_d = S_MARK;
			S_MARK:  state_d = S_DONE;
			S_FREE:  state_d = S_DONE;
			S_DONE: begin
				if (!sts.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_code = ST_DONE;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.req_free) begin
						if (sts.free_bad) begin
							cmd.res_load = 1'b1;
							cmd.res_code = ST_IGNORED;
						end
					end else if (sts.need_zero) begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_ZERO;
					end else if (sts.head_bad) begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_NOFIT;
					end
				end
			end
			S_WALK: begin
				if (sts.fit) begin
					cmd.load_found = 1'b1;
				end else if (sts.next_bad || sts.steps_over) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_NOFIT;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_SPLIT: cmd.wr_split = 1'b1;
			S_LINK:  cmd.wr_link = 1'b1;
			S_MARK: begin
				cmd.wr_mark  = 1'b1;
				cmd.res_load = 1'b1;
				cmd.grant    = 1'b1;
			end
			S_FREE: begin
				cmd.res_load = 1'b1;
				if (sts.mark_ok) begin
					cmd.free_wr = 1'b1;
				end else begin
					cmd.res_code = ST_IGNORED;
				end
			end
			S_DONE: cmd.out_load = !sts.out_busy;
			default: cmd = '0;
		endcase
	end
endmodule

/* hw/rtl/ffa_dp.sv */
// Datapath of the first-fit allocator: header store, walk registers, result.
module ffa_dp #(
	parameter int POOL_BYTES   = ffa_pkg::POOL_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
	parameter int SPLIT_SLACK  = ffa_pkg::SPLIT_SLACK_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          mode,
	input  logic [ffa_pkg::REQ_W-1:0]     request_size,
	input  logic [ffa_pkg::REL_W-1:0]     release_offset,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [1:0]                    status,
	output logic [ffa_pkg::OFFSET_W-1:0]  payload_offset,
	output logic [ffa_pkg::ID_W-1:0]      block_id,
	input  ffa_pkg::cmd_t                 cmd,
	output ffa_pkg::sts_t                 sts
);
	import ffa_pkg::*;

	localparam int ADDR_W = $clog2(POOL_BYTES);
	localparam int LINK_W = $clog2(POOL_BYTES + 2);
	localparam int WORD_W = LINK_W + ADDR_W;
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_BYTES);
	localparam logic [LINK_W-1:0] LINK_MARK = LINK_W'(POOL_BYTES + 1);
	localparam logic [CALC_W-1:0] POOL_C    = CALC_W'(POOL_BYTES);
	localparam logic [CALC_W-1:0] HDR_C     = CALC_W'(HEADER_BYTES);
	localparam logic [CALC_W-1:0] SPLIT_C   = CALC_W'(2 * HEADER_BYTES + SPLIT_SLACK);
	localparam logic [ADDR_W-1:0] INIT_SIZE = ADDR_W'(POOL_BYTES - HEADER_BYTES);
	localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(POOL_BYTES - 1);

	// architectural state
	logic              split_en_q;
	logic [LINK_W-1:0] list_head_q;
	logic [ID_W-1:0]   next_id_q;
	logic [ADDR_W-1:0] clr_q;

	// item and walk registers
	logic [REQ_W-1:0]  need_q;
	logic [ADDR_W-1:0] h_q;
	logic [ADDR_W-1:0] p_q;
	logic [ADDR_W-1:0] prev_q;
	logic [ADDR_W-1:0] prev_size_q;
	logic              at_head_q;
	logic [LINK_W-1:0] steps_q;
	logic [LINK_W-1:0] follower_q;
	logic [ADDR_W-1:0] size_p_q;
	logic [ADDR_W-1:0] np_q;
	logic [ADDR_W-1:0] rem_q;
	logic              split_q;

	// pending result and output register
	status_code_t      res_status_q;
	logic [OFFSET_W-1:0] res_off_q;
	logic [ID_W-1:0]   res_id_q;
	logic              out_valid_q;
	status_code_t      out_status_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic [ID_W-1:0]   out_id_q;

	// header store port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;
	logic [LINK_W-1:0] rd_next;
	logic [ADDR_W-1:0] rd_size;

	ffa_ram #(.WIDTH(WORD_W), .DEPTH(POOL_BYTES)) u_hdr (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_next = ram_rdata[WORD_W-1 -: LINK_W];
	assign rd_size = ram_rdata[ADDR_W-1:0];

	// live checks at accept
	logic [CALC_W-1:0] off_x, h_x;
	logic [ADDR_W-1:0] h_live, head_addr;
	assign off_x     = CALC_W'(release_offset);
	assign h_x       = off_x - HDR_C;
	assign h_live    = h_x[ADDR_W-1:0];
	assign head_addr = list_head_q[ADDR_W-1:0];

	// walk math on the header just read
	logic [CALC_W-1:0] need_x, size_x, p_x, np_x, rem_x, pay_x;
	logic [LINK_W-1:0] follower, target;
	logic              split_now;
	assign need_x    = CALC_W'(need_q);
	assign size_x    = CALC_W'(rd_size);
	assign p_x       = CALC_W'(p_q);
	assign np_x      = p_x + HDR_C + need_x;
	assign rem_x     = size_x - need_x - HDR_C;
	assign pay_x     = p_x + HDR_C;
	assign follower  = (rd_next == LINK_MARK) ? LINK_NULL : rd_next;
	assign split_now = split_en_q && (size_x > need_x + SPLIT_C) && (np_x < POOL_C);
	assign target    = split_q ? LINK_W'(np_q) : follower_q;

	always_comb begin
		if (cmd.walk_step) begin
			ram_raddr = rd_next[ADDR_W-1:0];
		end else if (mode) begin
			ram_raddr = h_live;
		end else begin
			ram_raddr = head_addr;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = p_q;
		ram_wdata = {LINK_MARK, split_q ? ADDR_W'(need_q) : size_p_q};
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = {LINK_NULL, (clr_q == '0) ? INIT_SIZE : '0};
		end else if (cmd.wr_split) begin
			ram_we    = 1'b1;
			ram_waddr = np_q;
			ram_wdata = {follower_q, rem_q};
		end else if (cmd.wr_link) begin
			ram_we    = !at_head_q;
			ram_waddr = prev_q;
			ram_wdata = {target, prev_size_q};
		end else if (cmd.wr_mark) begin
			ram_we    = 1'b1;
		end else if (cmd.free_wr) begin
			ram_we    = 1'b1;
			ram_waddr = h_q;
			ram_wdata = {list_head_q, rd_size};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_en_q  <= 1'b1;
			list_head_q <= '0;
			next_id_q   <= ID_W'(1);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) split_en_q <= cfg_wdata;
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.free_wr) begin
				list_head_q <= LINK_W'(h_q);
			end else if (cmd.wr_link && at_head_q) begin
				list_head_q <= target;
			end
			if (cmd.grant) next_id_q <= next_id_q + 1'b1;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			need_q    <= request_size;
			h_q       <= h_live;
			p_q       <= head_addr;
			at_head_q <= 1'b1;
			steps_q   <= '0;
		end
		if (cmd.walk_step) begin
			prev_q      <= p_q;
			prev_size_q <= rd_size;
			at_head_q   <= 1'b0;
			p_q         <= rd_next[ADDR_W-1:0];
			steps_q     <= steps_q + 1'b1;
		end
		if (cmd.load_found) begin
			follower_q <= follower;
			size_p_q   <= rd_size;
			np_q       <= np_x[ADDR_W-1:0];
			rem_q      <= rem_x[ADDR_W-1:0];
			split_q    <= split_now;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_code;
			res_off_q    <= cmd.grant ? pay_x[OFFSET_W-1:0] : '0;
			res_id_q     <= cmd.grant ? next_id_q : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_off_q    <= res_off_q;
			out_id_q     <= res_id_q;
		end
	end

	always_comb begin
		sts            = '0;
		sts.clr_done   = (clr_q == CLR_LAST);
		sts.req_free   = mode;
		sts.need_zero  = (request_size == '0);
		sts.head_bad   = (list_head_q >= LINK_NULL);
		sts.free_bad   = (off_x < HDR_C) || (off_x > POOL_C);
		sts.fit        = (size_x >= need_x);
		sts.next_bad   = (rd_next >= LINK_NULL);
		sts.steps_over = (steps_q >= LINK_NULL);
		sts.split_now  = split_now;
		sts.mark_ok    = (rd_next == LINK_MARK);
		sts.out_busy   = out_valid_q && out_stall;
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign payload_offset = out_off_q;
	assign block_id       = out_id_q;
endmodule

/* hw/rtl/ffa_checker.sv */
// Port-level checks of the allocator, bound to the top level.
module ffa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [1:0]                   status,
	input logic [ffa_pkg::OFFSET_W-1:0] payload_offset,
	input logic [ffa_pkg::ID_W-1:0]     block_id
);
	import ffa_pkg::*;

	// one item in flight: an accepted item blocks the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted back to back");

	// a rejected result carries neither an offset nor an id
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_DONE) |-> (payload_offset == '0) && (block_id == '0))
		else $error("rejected item carries offset or id");

	// result holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(payload_offset) && $stable(block_id))
		else $error("stalled result changed");

	// a free never returns an offset
	a_free_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DONE) && (block_id == '0) |-> payload_offset == '0)
		else $error("free result has offset");
endmodule

bind first_fit_free_list_allocator_core ffa_checker u_ffa_checker (.*);
